// File: rtl/gprc_pkg.sv
// Shared types, widths and register codes for the green pixel ratio and centroid unit.
// No dependencies; every other file imports this package.
package gprc_pkg;

   // Largest frame the unit is sized for.
   localparam int unsigned MAX_WIDTH  = 1024;
   localparam int unsigned MAX_HEIGHT = 1024;

   // Fixed field widths.
   localparam int unsigned LEVEL_W  = 8;
   localparam int unsigned COLUMN_W = 10;
   localparam int unsigned COUNT_W  = 21;
   localparam int unsigned CSUM_W   = 30;
   localparam int unsigned RATIO_W  = 17;
   localparam int unsigned CENTER_W = 16;
   localparam int unsigned CFG_DIM_W = 11;
   localparam int unsigned FRAC_W   = 16;
   localparam int unsigned STEP_W   = $clog2(FRAC_W);

   // Effective dimension width covers both the clamp limits and the raw register range.
   localparam int unsigned DIM_LIMIT = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
   localparam int unsigned DIM_MAX   = (DIM_LIMIT > (2**CFG_DIM_W - 1)) ?
                                       DIM_LIMIT : (2**CFG_DIM_W - 1);
   localparam int unsigned DIM_W     = $clog2(DIM_MAX + 1);
   localparam int unsigned AREA_W    = 2 * DIM_W;
   localparam int unsigned CW_W      = COUNT_W + DIM_W;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
   localparam logic [CSUM_W-1:0]  CSUM_MAX  = {CSUM_W{1'b1}};
   localparam logic [RATIO_W-1:0] RATIO_ONE = RATIO_W'(1) << FRAC_W;

   // Frame-end queue.
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

   // Register map.
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 17;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_GREEN    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DOM_MARGIN   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DETECT_RATIO = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 3'd4;

   typedef struct packed {
      logic [LEVEL_W-1:0]   red_level;
      logic [LEVEL_W-1:0]   green_level;
      logic [LEVEL_W-1:0]   blue_level;
      logic [COLUMN_W-1:0]  column;
      logic                 frame_end;
   } req_word_type;

   typedef struct packed {
      logic [COUNT_W-1:0]         green_count;
      logic [RATIO_W-1:0]         ratio_q16;
      logic signed [CENTER_W-1:0] center_q15;
      logic                       detected;
   } rsp_word_type;

   typedef struct packed {
      logic [LEVEL_W-1:0]   min_green;
      logic [LEVEL_W-1:0]   dominance_margin;
      logic [RATIO_W-1:0]   detect_ratio_q16;
      logic [CFG_DIM_W-1:0] frame_width;
      logic [CFG_DIM_W-1:0] frame_height;
   } csr_regs_type;

   typedef struct packed {
      logic [COUNT_W-1:0] green_total;
      logic [CSUM_W-1:0]  column_sum;
   } frame_sums_type;

   // Queue handshake between the front and back parts.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// File: rtl/gprc_front.sv
// Front part: classifies pixels and accumulates green count and column sum per frame.
// Depends on gprc_pkg.
module gprc_front (
   input  logic                  clock,
   input  logic                  reset,
   input  gprc_pkg::csr_regs_type csr_regs,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  gprc_pkg::req_word_type req_word,
   input  gprc_pkg::queue_status_type q_status,
   output logic                  q_push,
   output gprc_pkg::frame_sums_type q_push_data
);
   import gprc_pkg::*;

   logic [COUNT_W-1:0] total_ff, total_in, total_acc;
   logic [CSUM_W-1:0]  csum_ff, csum_in, csum_acc;
   logic [CSUM_W:0]    csum_wide;
   logic [LEVEL_W:0]   red_bound, blue_bound, green_ext;
   logic               is_green, accept;

   assign accept    = req_valid && req_ready;
   assign req_ready = !q_status.full;

   // Nine-bit compares, no wrap.
   assign green_ext  = {1'b0, req_word.green_level};
   assign red_bound  = {1'b0, req_word.red_level} + {1'b0, csr_regs.dominance_margin};
   assign blue_bound = {1'b0, req_word.blue_level} + {1'b0, csr_regs.dominance_margin};
   assign is_green   = (req_word.green_level > csr_regs.min_green) &&
                       (green_ext > red_bound) && (green_ext > blue_bound);

   assign csum_wide = {1'b0, csum_ff} + (CSUM_W+1)'(req_word.column);

   always_comb begin
      total_acc = total_ff;
      csum_acc  = csum_ff;
      if (is_green) begin
         if (total_ff != COUNT_MAX) total_acc = total_ff + COUNT_W'(1);
         csum_acc = csum_wide[CSUM_W] ? CSUM_MAX : csum_wide[CSUM_W-1:0];
      end
   end

   assign q_push                  = accept && req_word.frame_end;
   assign q_push_data.green_total = total_acc;
   assign q_push_data.column_sum  = csum_acc;

   always_comb begin
      total_in = total_ff;
      csum_in  = csum_ff;
      if (accept) begin
         // Clear on frame end; the finished sums go to the queue.
         total_in = req_word.frame_end ? '0 : total_acc;
         csum_in  = req_word.frame_end ? '0 : csum_acc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
         csum_ff  <= '0;
      end else begin
         total_ff <= total_in;
         csum_ff  <= csum_in;
      end
   end

endmodule

// File: rtl/gprc_queue.sv
// Short queue of finished frame sums between the front and back parts.
// Depends on gprc_pkg.
module gprc_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  gprc_pkg::frame_sums_type   push_data,
   input  logic                       pop,
   output gprc_pkg::frame_sums_type   pop_data,
   output gprc_pkg::queue_status_type status
);
   import gprc_pkg::*;

   frame_sums_type        slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]     count_ff, count_in;
   logic                  do_push, do_pop;

   assign status.full  = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_data     = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == QUEUE_AW'(QUEUE_DEPTH-1)) ? '0 :
                               wr_ptr_ff + QUEUE_AW'(1);
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == QUEUE_AW'(QUEUE_DEPTH-1)) ? '0 :
                               rd_ptr_ff + QUEUE_AW'(1);
      if (do_push && !do_pop) count_in = count_ff + (QUEUE_AW+1)'(1);
      if (do_pop && !do_push) count_in = count_ff - (QUEUE_AW+1)'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push_data;
   end

endmodule

// File: rtl/gprc_back.sv
// Back part: turns frame sums into ratio, centroid and detect flag with two bit-serial
// dividers, and holds the result word. Depends on gprc_pkg.
module gprc_back (
   input  logic                       clock,
   input  logic                       reset,
   input  gprc_pkg::csr_regs_type     csr_regs,
   input  gprc_pkg::queue_status_type q_status,
   input  gprc_pkg::frame_sums_type   q_pop_data,
   output logic                       q_pop,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output gprc_pkg::rsp_word_type     rsp_word
);
   import gprc_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_MULT   = 5'b00010,
      ST_PREP   = 5'b00100,
      ST_DIVIDE = 5'b01000,
      ST_FINISH = 5'b10000
   } back_state_type;

   back_state_type      state_ff, state_in;
   logic [COUNT_W-1:0]  cnt_ff, cnt_in;
   logic [CSUM_W-1:0]   csum_ff, csum_in;
   logic [AREA_W-1:0]   area_ff, area_in;
   logic [CW_W-1:0]     cw_ff, cw_in;
   logic [AREA_W:0]     rrem_ff, rrem_in, rrem_shift;
   logic [CW_W:0]       crem_ff, crem_in, crem_shift;
   logic [FRAC_W-1:0]   rquo_ff, rquo_in, cquo_ff, cquo_in;
   logic                rsat_ff, rsat_in, csat_ff, csat_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic                out_valid_ff, out_valid_in;
   rsp_word_type        out_word_ff, out_word_in;
   logic [DIM_W-1:0]    eff_w, eff_h, raw_w, raw_h;
   logic [RATIO_W-1:0]  ratio_val;
   logic [CENTER_W-1:0] center_val;
   logic                slot_free;

   // Clamp dimensions to 1..MAX.
   assign raw_w = DIM_W'(csr_regs.frame_width);
   assign raw_h = DIM_W'(csr_regs.frame_height);
   assign eff_w = (raw_w == '0) ? DIM_W'(1) :
                  (raw_w > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : raw_w;
   assign eff_h = (raw_h == '0) ? DIM_W'(1) :
                  (raw_h > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : raw_h;

   assign rrem_shift = {rrem_ff[AREA_W-1:0], 1'b0};
   assign crem_shift = {crem_ff[CW_W-1:0], 1'b0};

   assign ratio_val  = rsat_ff ? RATIO_ONE : RATIO_W'(rquo_ff);
   // Offset by half scale: flip the top bit.
   assign center_val = (cnt_ff == '0) ? '0 :
                       csat_ff ? {1'b0, {(CENTER_W-1){1'b1}}} :
                       {~cquo_ff[FRAC_W-1], cquo_ff[FRAC_W-2:0]};

   assign slot_free = !out_valid_ff || rsp_ready;
   assign q_pop     = (state_ff == ST_IDLE) && !q_status.empty;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      csum_in      = csum_ff;
      area_in      = area_ff;
      cw_in        = cw_ff;
      rrem_in      = rrem_ff;
      crem_in      = crem_ff;
      rquo_in      = rquo_ff;
      cquo_in      = cquo_ff;
      rsat_in      = rsat_ff;
      csat_in      = csat_ff;
      step_in      = step_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_word_in  = out_word_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty) begin
               cnt_in   = q_pop_data.green_total;
               csum_in  = q_pop_data.column_sum;
               state_in = ST_MULT;
            end
         end
         ST_MULT: begin
            area_in  = AREA_W'(eff_w) * AREA_W'(eff_h);
            cw_in    = CW_W'(cnt_ff) * CW_W'(eff_w);
            state_in = ST_PREP;
         end
         ST_PREP: begin
            // Quotient of at least one full scale saturates; else remainder starts below divisor.
            rsat_in  = (AREA_W'(cnt_ff) >= area_ff);
            csat_in  = (CW_W'(csum_ff) >= cw_ff);
            rrem_in  = (AREA_W+1)'(cnt_ff);
            crem_in  = (CW_W+1)'(csum_ff);
            rquo_in  = '0;
            cquo_in  = '0;
            step_in  = '0;
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (rrem_shift >= {1'b0, area_ff}) begin
               rrem_in = rrem_shift - {1'b0, area_ff};
               rquo_in = {rquo_ff[FRAC_W-2:0], 1'b1};
            end else begin
               rrem_in = rrem_shift;
               rquo_in = {rquo_ff[FRAC_W-2:0], 1'b0};
            end
            if (crem_shift >= {1'b0, cw_ff}) begin
               crem_in = crem_shift - {1'b0, cw_ff};
               cquo_in = {cquo_ff[FRAC_W-2:0], 1'b1};
            end else begin
               crem_in = crem_shift;
               cquo_in = {cquo_ff[FRAC_W-2:0], 1'b0};
            end
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(FRAC_W-1)) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (slot_free) begin
               out_valid_in            = 1'b1;
               out_word_in.green_count = cnt_ff;
               out_word_in.ratio_q16   = ratio_val;
               out_word_in.center_q15  = center_val;
               out_word_in.detected    = (ratio_val > csr_regs.detect_ratio_q16);
               state_in                = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         step_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         step_ff      <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      csum_ff     <= csum_in;
      area_ff     <= area_in;
      cw_ff       <= cw_in;
      rrem_ff     <= rrem_in;
      crem_ff     <= crem_in;
      rquo_ff     <= rquo_in;
      cquo_ff     <= cquo_in;
      rsat_ff     <= rsat_in;
      csat_ff     <= csat_in;
      out_word_ff <= out_word_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

endmodule

// File: rtl/green_pixel_ratio_centroid_unit.sv
// Top level of the green pixel ratio and centroid unit: register file, front, queue, back.
// Depends on gprc_pkg, gprc_front, gprc_queue and gprc_back.
//
//   channel | direction | word            | handshake
//   --------+-----------+-----------------+----------------------
//   req     | in        | req_word_type   | req_valid / req_ready
//   rsp     | out       | rsp_word_type   | rsp_valid / rsp_ready
//   csr     | in        | index + data    | csr_valid / csr_ready
//
// Pixels are taken one per clock while the frame-end queue has room; a pixel
// without the frame-end mark gives no word.
// Each frame end passes through the back part in order (fetch, multiply, setup,
// 16 one-bit steps of the two dividers, load) before the next one is fetched.
// The queue holds two finished frames, so the pixel side stalls only when short
// frames arrive back to back faster than the back part finishes them or rsp stalls long.
// Reset (synchronous, active high) restores the register defaults and clears
// the accumulators, the queue and the output valid flag.
module green_pixel_ratio_centroid_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  gprc_pkg::req_word_type          req_word,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output gprc_pkg::rsp_word_type          rsp_word,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [gprc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [gprc_pkg::CSR_DATA_W-1:0]  csr_data
);
   import gprc_pkg::*;

   csr_regs_type     regs_ff, regs_in;
   queue_status_type q_status;
   frame_sums_type   q_push_data, q_pop_data;
   logic             q_push, q_pop;

   // Registers accept a write every cycle.
   assign csr_ready = 1'b1;

   // Decode the write; drop indexes beyond the map.
   always_comb begin
      regs_in = regs_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_MIN_GREEN:    regs_in.min_green        = csr_data[LEVEL_W-1:0];
            CSR_DOM_MARGIN:   regs_in.dominance_margin = csr_data[LEVEL_W-1:0];
            CSR_DETECT_RATIO: regs_in.detect_ratio_q16 = csr_data[RATIO_W-1:0];
            CSR_FRAME_WIDTH:  regs_in.frame_width      = csr_data[CFG_DIM_W-1:0];
            CSR_FRAME_HEIGHT: regs_in.frame_height     = csr_data[CFG_DIM_W-1:0];
            default:          regs_in = regs_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff.min_green        <= LEVEL_W'(100);
         regs_ff.dominance_margin <= LEVEL_W'(40);
         regs_ff.detect_ratio_q16 <= RATIO_W'(655);
         regs_ff.frame_width      <= CFG_DIM_W'(64);
         regs_ff.frame_height     <= CFG_DIM_W'(64);
      end else begin
         regs_ff <= regs_in;
      end
   end

   // Front: classify and accumulate, push sums on frame end.
   gprc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_regs    (regs_ff),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_word    (req_word),
      .q_status    (q_status),
      .q_push      (q_push),
      .q_push_data (q_push_data)
   );

   // Hold finished frames so the pixel side keeps moving during the divisions.
   gprc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .status    (q_status)
   );

   // Back: divide, saturate, compare, drive the result word.
   gprc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_regs   (regs_ff),
      .q_status   (q_status),
      .q_pop_data (q_pop_data),
      .q_pop      (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_word   (rsp_word)
   );

endmodule

// File: rtl/gprc_checker.sv
// Port-level checks for the green pixel ratio and centroid unit, bound to the top level.
// Depends on gprc_pkg.
module gprc_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input gprc_pkg::rsp_word_type rsp_word,
   input logic                   csr_ready
);
   import gprc_pkg::*;

   // Hold a stalled result word.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("rsp word changed while stalled");

   // An empty frame gives zero ratio, centered output and no detection.
   a_empty_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.green_count == '0 |->
         rsp_word.ratio_q16 == '0 && rsp_word.center_q15 == '0 && !rsp_word.detected)
      else $error("empty frame gave nonzero result");

   // Ratio saturates at one.
   a_ratio_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_word.ratio_q16 <= RATIO_ONE)
      else $error("ratio above full scale");

   // No word right after reset.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   // Register writes never stall outside reset.
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_ready)
      else $error("csr port stalled");

endmodule

bind green_pixel_ratio_centroid_unit gprc_checker u_gprc_checker (.*);

// File: tb/green_pixel_ratio_centroid_unit_tb.sv
// Self-checking testbench for green_pixel_ratio_centroid_unit: pixel stream in,
// per-frame count, ratio, centroid and detect word out, checked against a local predictor.
// Depends on gprc_pkg and the unit's RTL only.
module green_pixel_ratio_centroid_unit_tb;
   import gprc_pkg::*;

   localparam int unsigned QUIET_CYCLES  = 60;
   localparam int unsigned PHASE_PIXELS  = 140;
   localparam int unsigned RANDOM_PHASES = 9;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_word_type           req_word  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_word_type           rsp_word;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data  = '0;

   // Predictor copy of the register file and the frame accumulators.
   logic [LEVEL_W-1:0]   cfg_min_green;
   logic [LEVEL_W-1:0]   cfg_margin;
   logic [RATIO_W-1:0]   cfg_detect;
   logic [CFG_DIM_W-1:0] cfg_width;
   logic [CFG_DIM_W-1:0] cfg_height;
   logic [COUNT_W-1:0]   green_total;
   logic [CSUM_W-1:0]    column_sum;

   req_word_type pixel_backlog[$];
   rsp_word_type frame_results_due[$];
   rsp_word_type due_word;

   int unsigned send_idle_pct = 21;
   int unsigned recv_idle_pct = 50;
   logic        req_taken     = 1'b0;
   int unsigned pixels_taken    = 0;
   int unsigned frames_checked  = 0;
   int unsigned mismatch_count  = 0;
   int unsigned settings_loaded = 0;

   green_pixel_ratio_centroid_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Clamp a dimension register to the range the unit divides by.
   function automatic longint unsigned eff_dim(input logic [CFG_DIM_W-1:0] v,
                                               input longint unsigned limit);
      longint unsigned d;
      d = v;
      if (d == 0) d = 1;
      if (d > limit) d = limit;
      return d;
   endfunction

   // Classify one pixel, fold it into the sums, and on frame end queue the word due.
   task automatic account_pixel(input req_word_type px);
      longint unsigned w, h, cnt, ratio, centre, csum_next;
      rsp_word_type res;
      // Compare in 32 bits so green must beat level + margin without wrap.
      if (px.green_level > cfg_min_green
          && 32'(px.green_level) > 32'(px.red_level) + 32'(cfg_margin)
          && 32'(px.green_level) > 32'(px.blue_level) + 32'(cfg_margin)) begin
         if (green_total != COUNT_MAX) green_total = green_total + COUNT_W'(1);
         csum_next = 64'(column_sum) + 64'(px.column);
         column_sum = (csum_next > 64'(CSUM_MAX)) ? CSUM_MAX : CSUM_W'(csum_next);
      end
      if (!px.frame_end) return;
      w   = eff_dim(cfg_width, MAX_WIDTH);
      h   = eff_dim(cfg_height, MAX_HEIGHT);
      cnt = green_total;
      ratio = (cnt << 16) / (w * h);
      if (ratio > 65536) ratio = 65536;
      if (cnt == 0) begin
         res.center_q15 = '0;
      end else begin
         centre = (64'(column_sum) << 16) / (cnt * w);
         if (centre > 65535) centre = 65535;
         // Shift the unsigned 0..65535 position down to two's complement -1..1.
         res.center_q15 = CENTER_W'(centre - 32768);
      end
      res.green_count = green_total;
      res.ratio_q16   = RATIO_W'(ratio);
      res.detected    = (ratio > 64'(cfg_detect));
      frame_results_due.push_back(res);
      green_total = '0;
      column_sum  = '0;
   endtask

   task automatic report_mismatch(input string field, input longint got, input longint want);
      $display("mismatch on result word %0d: %s = %0d, expected %0d",
               frames_checked, field, got, want);
      mismatch_count++;
   endtask

   function automatic req_word_type pixel_of(input int unsigned r, input int unsigned g,
                                             input int unsigned b, input int unsigned col,
                                             input bit is_last);
      req_word_type px;
      px.red_level   = LEVEL_W'(r);
      px.green_level = LEVEL_W'(g);
      px.blue_level  = LEVEL_W'(b);
      px.column      = COLUMN_W'(col);
      px.frame_end   = is_last;
      return px;
   endfunction

   // Build a random pixel; green candidates sit near the thresholds now in force.
   function automatic req_word_type make_pixel(input bit want_green, input bit is_last);
      req_word_type px;
      int unsigned g, eff_w;
      eff_w = int'(eff_dim(cfg_width, MAX_WIDTH));
      px.red_level   = LEVEL_W'($urandom);
      px.green_level = LEVEL_W'($urandom);
      px.blue_level  = LEVEL_W'($urandom);
      if (want_green) begin
         g = $urandom_range(255, cfg_min_green);
         px.green_level = LEVEL_W'(g);
         if (g > cfg_margin) begin
            px.red_level  = LEVEL_W'($urandom_range(g - cfg_margin, 0));
            px.blue_level = LEVEL_W'($urandom_range(g - cfg_margin, 0));
         end
      end
      // Mostly columns inside the frame, sometimes anywhere in the field.
      if ($urandom_range(4, 0) != 0) px.column = COLUMN_W'($urandom_range(eff_w - 1, 0));
      else px.column = COLUMN_W'($urandom);
      px.frame_end = is_last;
      return px;
   endfunction

   task automatic queue_frame(input int unsigned len, inout int unsigned queued);
      for (int unsigned i = 0; i < len; i++) begin
         pixel_backlog.push_back(make_pixel(1'($urandom_range(1, 0)), i == len - 1));
         queued++;
      end
   endtask

   // Hold one register word on the channel until it is taken; leave valid high.
   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!(csr_valid && csr_ready)) @(posedge clock);
   endtask

   // Write every register, then optionally poke the unused indexes, then drop valid.
   task automatic load_settings(input logic [CSR_DATA_W-1:0] min_green,
                                input logic [CSR_DATA_W-1:0] margin,
                                input logic [CSR_DATA_W-1:0] detect,
                                input logic [CSR_DATA_W-1:0] width,
                                input logic [CSR_DATA_W-1:0] height,
                                input bit with_spare);
      csr_write(CSR_MIN_GREEN, min_green);
      csr_write(CSR_DOM_MARGIN, margin);
      csr_write(CSR_DETECT_RATIO, detect);
      csr_write(CSR_FRAME_WIDTH, width);
      csr_write(CSR_FRAME_HEIGHT, height);
      if (with_spare) begin
         for (int i = int'(CSR_FRAME_HEIGHT) + 1; i < 2**CSR_INDEX_W; i++) begin
            csr_write(CSR_INDEX_W'(i), CSR_DATA_W'($urandom));
         end
      end
      @(negedge clock);
      csr_valid <= 1'b0;
      settings_loaded++;
   endtask

   // Wait until every pixel is taken and every word has arrived, then let the
   // back stage run dry before touching the registers.
   task automatic wait_quiet();
      while (pixel_backlog.size() != 0 || req_valid || frame_results_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   // Pixel driver and result-side stall generator: change inputs on the falling edge.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         // Hold the current word until the unit takes it.
         if (!req_valid || req_taken) begin
            if (pixel_backlog.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_word  <= pixel_backlog.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
      end
   end

   // Monitor: sample handshakes at the rising edge, advance the predictor, check words.
   always @(posedge clock) begin
      if (reset) begin
         cfg_min_green = 8'd100;
         cfg_margin    = 8'd40;
         cfg_detect    = 17'd655;
         cfg_width     = 11'd64;
         cfg_height    = 11'd64;
         green_total   = '0;
         column_sum    = '0;
         frame_results_due.delete();
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (csr_valid && csr_ready) begin
            // Drop the bits above each register's width; ignore unused indexes.
            case (csr_index)
               CSR_MIN_GREEN:    cfg_min_green = csr_data[LEVEL_W-1:0];
               CSR_DOM_MARGIN:   cfg_margin    = csr_data[LEVEL_W-1:0];
               CSR_DETECT_RATIO: cfg_detect    = csr_data[RATIO_W-1:0];
               CSR_FRAME_WIDTH:  cfg_width     = csr_data[CFG_DIM_W-1:0];
               CSR_FRAME_HEIGHT: cfg_height    = csr_data[CFG_DIM_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            account_pixel(req_word);
            pixels_taken++;
         end
         if (rsp_valid && rsp_ready) begin
            if (frame_results_due.size() == 0) begin
               report_mismatch("word with no frame end pending, green_count",
                               rsp_word.green_count, 0);
            end else begin
               due_word = frame_results_due.pop_front();
               if (rsp_word.green_count !== due_word.green_count)
                  report_mismatch("green_count", rsp_word.green_count, due_word.green_count);
               if (rsp_word.ratio_q16 !== due_word.ratio_q16)
                  report_mismatch("ratio_q16", rsp_word.ratio_q16, due_word.ratio_q16);
               if (rsp_word.center_q15 !== due_word.center_q15)
                  report_mismatch("center_q15", $signed(rsp_word.center_q15),
                                  $signed(due_word.center_q15));
               if (rsp_word.detected !== due_word.detected)
                  report_mismatch("detected", rsp_word.detected, due_word.detected);
            end
            frames_checked++;
         end
      end
   end

   // Stimulus sequence: directed corners first, then random register settings.
   initial begin
      int unsigned queued;
      int unsigned pick;
      logic [CSR_DATA_W-1:0] set_min, set_margin, set_detect, set_width, set_height;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset thresholds: empty frame, green exactly past each limit, misses
      // by one on level and on each margin, centroid at both ends.
      pixel_backlog.push_back(pixel_of(0, 0, 0, 0, 1));
      pixel_backlog.push_back(pixel_of(60, 101, 60, 1023, 0));
      pixel_backlog.push_back(pixel_of(0, 100, 0, 5, 0));
      pixel_backlog.push_back(pixel_of(61, 101, 0, 7, 0));
      pixel_backlog.push_back(pixel_of(0, 101, 61, 9, 0));
      pixel_backlog.push_back(pixel_of(214, 255, 214, 0, 0));
      pixel_backlog.push_back(pixel_of(255, 255, 255, 512, 1));
      pixel_backlog.push_back(pixel_of(0, 255, 0, 0, 1));
      pixel_backlog.push_back(pixel_of(0, 255, 0, 63, 1));
      wait_quiet();

      // One-pixel frame (height 0 read as 1) with stray register bits: ratio and
      // centroid saturate, a threshold above one never detects, unused indexes do nothing.
      load_settings(0, 0, 65536, {6'h2a, 11'd1}, 0, 1'b1);
      pixel_backlog.push_back(pixel_of(0, 0, 0, 0, 1));
      pixel_backlog.push_back(pixel_of(0, 1, 0, 1023, 0));
      pixel_backlog.push_back(pixel_of(0, 1, 0, 1023, 1));
      pixel_backlog.push_back(pixel_of(255, 255, 255, 1023, 1));
      wait_quiet();

      // Oversized frame clamps to the maximum; margins at the nine-bit edge.
      load_settings(254, 254, 0, 2047, 2047, 1'b0);
      pixel_backlog.push_back(pixel_of(0, 255, 0, 1000, 0));
      pixel_backlog.push_back(pixel_of(1, 255, 0, 3, 0));
      pixel_backlog.push_back(pixel_of(0, 255, 1, 3, 0));
      pixel_backlog.push_back(pixel_of(0, 254, 0, 3, 0));
      pixel_backlog.push_back(pixel_of(0, 0, 0, 0, 1));
      wait_quiet();

      load_settings(255, 255, 65535, 1, 1, 1'b0);
      pixel_backlog.push_back(pixel_of(0, 255, 0, 0, 1));
      wait_quiet();

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         // Receiver-heavy stalls, then sender-heavy, then none.
         case (ph / 3)
            0: begin send_idle_pct = 21; recv_idle_pct = 50; end
            1: begin send_idle_pct = 50; recv_idle_pct = 21; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase

         pick = $urandom_range(7, 0);
         set_min = CSR_DATA_W'((pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 :
                               8'($urandom_range(150, 0)));
         pick = $urandom_range(7, 0);
         set_margin = CSR_DATA_W'((pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 :
                                  8'($urandom_range(90, 0)));
         set_min    = {9'($urandom), set_min[LEVEL_W-1:0]};
         set_margin = {9'($urandom), set_margin[LEVEL_W-1:0]};
         case ($urandom_range(7, 0))
            0: set_detect = 17'd0;
            1: set_detect = 17'd65536;
            2: set_detect = 17'd65535;
            default: set_detect = 17'($urandom_range(20000, 0));
         endcase
         case ($urandom_range(9, 0))
            0: set_width = 17'd0;
            1: set_width = 17'd2047;
            2: set_width = 17'd1024;
            3: set_width = 17'd1;
            default: set_width = 17'($urandom_range(64, 2));
         endcase
         case ($urandom_range(9, 0))
            0: set_height = 17'd0;
            1: set_height = 17'd2047;
            2: set_height = 17'd1;
            default: set_height = 17'($urandom_range(16, 2));
         endcase
         set_width  = {6'($urandom), set_width[CFG_DIM_W-1:0]};
         set_height = {6'($urandom), set_height[CFG_DIM_W-1:0]};
         load_settings(set_min, set_margin, set_detect, set_width, set_height, 1'b0);

         // Mostly modest frames, bursts of tiny ones to fill the frame-end queue,
         // and the odd long frame.
         queued = 0;
         while (queued < PHASE_PIXELS) begin
            case ($urandom_range(19, 0))
               0:       queue_frame($urandom_range(400, 100), queued);
               1, 2, 3: queue_frame($urandom_range(3, 1), queued);
               default: queue_frame($urandom_range(40, 4), queued);
            endcase
         end
         wait_quiet();
      end

      $display("Covered %0d pixels and %0d result words over %0d register settings,",
               pixels_taken, frames_checked, settings_loaded + 1);
      $display("with sender- and receiver-side stalls in both proportions and a stall-free run.");
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Watchdog: a stuck handshake or a missing word ends the run here.
   initial begin
      #2000000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

// File: green_pixel_ratio_centroid_unit.f
rtl/gprc_pkg.sv
rtl/gprc_front.sv
rtl/gprc_queue.sv
rtl/gprc_back.sv
rtl/green_pixel_ratio_centroid_unit.sv
rtl/gprc_checker.sv
tb/green_pixel_ratio_centroid_unit_tb.sv
